// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock edge, off while reset is asserted
`define GCD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication form, antecedent and consequent on the same edge
`define GCD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/gcd_pkg.sv
`default_nettype none

package gcd_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int SQRT_STEPS   = 31;

  // mag, quotient, turn, cordic, three product stages, root, vectoring, two scale stages
  localparam int LATENCY = 3 + CORDIC_STEPS + 3 + SQRT_STEPS + CORDIC_STEPS + 2;

  localparam int DIV_TURN = 45;
  localparam logic [26:0] RECIP45 = 27'd95443718;  // ceil(2^32 / 45)

  localparam logic signed [33:0] INV_GAIN = 34'sd652032874;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // 5246834913 split into a 17 bit high part and a 16 bit low part
  localparam logic [16:0] DIST_KHI = 17'd80060;
  localparam logic [15:0] DIST_KLO = 16'd22753;
  localparam logic [63:0] DIST_RND = 64'h0000_0080_0000_0000;

  localparam logic [22:0] DIST_MAX = 23'd5124000;

  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef logic [11:0] frac_lut_t [DIV_TURN];

  // round((4096 * r) / 45), ties up, for each remainder
  function automatic frac_lut_t build_frac_lut();
    frac_lut_t lut;
    for (int r = 0; r < DIV_TURN; r++) begin
      lut[r] = 12'((4096 * r + 22) / DIV_TURN);
    end
    return lut;
  endfunction

  localparam frac_lut_t FRAC_LUT = build_frac_lut();

  function automatic logic [11:0] turn_frac(logic [5:0] r);
    logic [11:0] f;
    f = 12'd0;
    if (r < 6'(DIV_TURN)) begin
      f = FRAC_LUT[r];
    end
    return f;
  endfunction

endpackage

`default_nettype wire

// File: rtl/great_circle_distance_top.sv
// haversine great-circle distance, one point pair in, one distance out
//
// input channel: in_valid_i / in_ready_o, with lat_a_i, lon_a_i, lat_b_i,
// lon_b_i in degrees with 16 fraction bits; a transfer happens on a rising
// edge with valid and ready both high
// output channel: out_valid_o / out_ready_i, distance_o in km with 8
// fraction bits on a 6371 km sphere
//
// 71 register stages: three of degree-to-turn conversion, 16 sine/cosine
// cordic stages, three product stages, 31 square root stages, 16 atan2
// vectoring stages and two scaling stages; formula 39 + 2 * cordic steps
// out_valid_o is the valid bit of the last stage, marching with the data
// throughput is one pair per cycle while the receiver does not stall, every stage holds one item
//
// the whole pipe advances together; when the receiver stalls with a result
// waiting, every stage holds and in_ready_o drops in the same cycle, so no
// item is lost or repeated; bubbles travel as cleared valid bits
// reset clears only the valid bits, the datapath registers carry no reset
`default_nettype none

module great_circle_distance_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [23:0] lat_a_i,
  input  logic signed [24:0] lon_a_i,
  input  logic signed [23:0] lat_b_i,
  input  logic signed [24:0] lon_b_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic        [22:0] distance_o
);
  import gcd_pkg::*;

  logic en;
  logic [LATENCY-1:0] vld_q;

  assign en          = !vld_q[LATENCY-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[LATENCY-1];

  // valid bits march with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LATENCY-2:0], in_valid_i};
    end
  end

  // ---------------------------------------------------------------------
  // degree to turn conversion, lanes: half dlat, half dlon, lat_a, lat_b
  // every lane is turn = round(m * 4096 / 45)
  // ---------------------------------------------------------------------
  logic signed [25:0] m_s [4];
  logic [25:0] mag_d [4];
  logic [25:0] mag_q [4];
  logic        sgn_q [4];

  always_comb begin
    m_s[0] = 26'(lat_b_i) - 26'(lat_a_i);
    m_s[1] = 26'(lon_b_i) - 26'(lon_a_i);
    m_s[2] = $signed({lat_a_i[23], lat_a_i, 1'b0});
    m_s[3] = $signed({lat_b_i[23], lat_b_i, 1'b0});
    for (int l = 0; l < 4; l++) begin
      mag_d[l] = m_s[l][25] ? 26'(-m_s[l]) : 26'(m_s[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        mag_q[l] <= mag_d[l];
        sgn_q[l] <= m_s[l][25];
      end
    end
  end

  // quotient by 45 through the reciprocal, exact for 26 bit magnitudes
  logic [52:0] quo_prod [4];
  logic [20:0] quo_q  [4];
  logic [25:0] mag2_q [4];
  logic        sgn2_q [4];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      quo_prod[l] = 53'(mag_q[l]) * 53'(RECIP45);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        quo_q[l]  <= quo_prod[l][52:32];
        mag2_q[l] <= mag_q[l];
        sgn2_q[l] <= sgn_q[l];
      end
    end
  end

  // remainder picks the low 12 bits of the rounded turn
  logic [5:0]  rem45 [4];
  logic [32:0] turn_mag [4];
  logic [31:0] turn_d [4];
  logic [31:0] turn_q [4];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      rem45[l]    = 6'(mag2_q[l] - 26'(quo_q[l]) * 26'(DIV_TURN));
      turn_mag[l] = {quo_q[l], turn_frac(rem45[l])};
      turn_d[l]   = sgn2_q[l] ? 32'(-turn_mag[l]) : turn_mag[l][31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      turn_q <= turn_d;
    end
  end

  // ---------------------------------------------------------------------
  // sine / cosine cordic, rotation mode, one iteration per stage
  // angle is first folded into the right half-plane
  // ---------------------------------------------------------------------
  logic signed [33:0] rin_x [CORDIC_STEPS][4];
  logic signed [33:0] rin_y [CORDIC_STEPS][4];
  logic signed [33:0] rin_z [CORDIC_STEPS][4];
  logic               rin_n [CORDIC_STEPS][4];
  logic signed [33:0] rot_x_d [CORDIC_STEPS][4];
  logic signed [33:0] rot_y_d [CORDIC_STEPS][4];
  logic signed [33:0] rot_z_d [CORDIC_STEPS][4];
  logic signed [33:0] rot_x_q [CORDIC_STEPS][4];
  logic signed [33:0] rot_y_q [CORDIC_STEPS][4];
  logic signed [33:0] rot_z_q [CORDIC_STEPS][4];
  logic               rot_n_q [CORDIC_STEPS][4];
  logic [31:0]        fold [4];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      fold[l] = turn_q[l];
      if (turn_q[l][31] ^ turn_q[l][30]) begin
        fold[l][31] = ~turn_q[l][31];
      end
      rin_x[0][l] = INV_GAIN;
      rin_y[0][l] = '0;
      rin_z[0][l] = 34'($signed(fold[l]));
      rin_n[0][l] = turn_q[l][31] ^ turn_q[l][30];
    end
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      for (int l = 0; l < 4; l++) begin
        rin_x[i][l] = rot_x_q[i-1][l];
        rin_y[i][l] = rot_y_q[i-1][l];
        rin_z[i][l] = rot_z_q[i-1][l];
        rin_n[i][l] = rot_n_q[i-1][l];
      end
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      for (int l = 0; l < 4; l++) begin
        if (!rin_z[i][l][33]) begin
          rot_x_d[i][l] = rin_x[i][l] - (rin_y[i][l] >>> i);
          rot_y_d[i][l] = rin_y[i][l] + (rin_x[i][l] >>> i);
          rot_z_d[i][l] = rin_z[i][l] - 34'(ATAN_TURNS[i]);
        end else begin
          rot_x_d[i][l] = rin_x[i][l] + (rin_y[i][l] >>> i);
          rot_y_d[i][l] = rin_y[i][l] - (rin_x[i][l] >>> i);
          rot_z_d[i][l] = rin_z[i][l] + 34'(ATAN_TURNS[i]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rot_x_q <= rot_x_d;
      rot_y_q <= rot_y_d;
      rot_z_q <= rot_z_d;
      rot_n_q <= rin_n;
    end
  end

  // ---------------------------------------------------------------------
  // haversine term a = s1^2 + c1*c2*s2^2, clamped to [0, 1]
  // ---------------------------------------------------------------------
  logic signed [31:0] sin_dlat, sin_dlon, cos_a, cos_b;
  logic signed [63:0] p_sq1, p_sq2, p_cc, p_t2;
  logic signed [31:0] sq1_q, sq2_q, cc_q, sq1b_q, t2_q;
  logic signed [32:0] hav_sum;
  logic [30:0]        hav_d;
  logic [30:0]        hav_q, hinv_q;

  always_comb begin
    sin_dlat = rot_n_q[CORDIC_STEPS-1][0] ? 32'(-rot_y_q[CORDIC_STEPS-1][0])
                                          : 32'(rot_y_q[CORDIC_STEPS-1][0]);
    sin_dlon = rot_n_q[CORDIC_STEPS-1][1] ? 32'(-rot_y_q[CORDIC_STEPS-1][1])
                                          : 32'(rot_y_q[CORDIC_STEPS-1][1]);
    cos_a    = rot_n_q[CORDIC_STEPS-1][2] ? 32'(-rot_x_q[CORDIC_STEPS-1][2])
                                          : 32'(rot_x_q[CORDIC_STEPS-1][2]);
    cos_b    = rot_n_q[CORDIC_STEPS-1][3] ? 32'(-rot_x_q[CORDIC_STEPS-1][3])
                                          : 32'(rot_x_q[CORDIC_STEPS-1][3]);
    p_sq1 = 64'(sin_dlat) * 64'(sin_dlat);
    p_sq2 = 64'(sin_dlon) * 64'(sin_dlon);
    p_cc  = 64'(cos_a) * 64'(cos_b);
    p_t2  = 64'(cc_q) * 64'(sq2_q);
    hav_sum = 33'(sq1b_q) + 33'(t2_q);
    if (hav_sum[32]) begin
      hav_d = '0;
    end else if (hav_sum > 33'(ONE_Q30)) begin
      hav_d = ONE_Q30;
    end else begin
      hav_d = hav_sum[30:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq1_q  <= 32'(p_sq1 >>> 30);
      sq2_q  <= 32'(p_sq2 >>> 30);
      cc_q   <= 32'(p_cc >>> 30);
      sq1b_q <= sq1_q;
      t2_q   <= 32'(p_t2 >>> 30);
      hav_q  <= hav_d;
      hinv_q <= ONE_Q30 - hav_d;
    end
  end

  // ---------------------------------------------------------------------
  // sqrt(a) and sqrt(1-a), restoring digit recurrence, one bit per stage
  // lane 0 holds a, lane 1 holds 1 - a, both scaled by 2^30
  // ---------------------------------------------------------------------
  logic [30:0] sin_val [SQRT_STEPS][2];
  logic [31:0] sin_root [SQRT_STEPS][2];
  logic [34:0] sin_rem [SQRT_STEPS][2];
  logic [61:0] sq_word [SQRT_STEPS][2];
  logic [34:0] sq_next [SQRT_STEPS][2];
  logic [34:0] sq_trial [SQRT_STEPS][2];
  logic [31:0] sq_root_d [SQRT_STEPS][2];
  logic [34:0] sq_rem_d [SQRT_STEPS][2];
  logic [30:0] sq_val_q [SQRT_STEPS][2];
  logic [31:0] sq_root_q [SQRT_STEPS][2];
  logic [34:0] sq_rem_q [SQRT_STEPS][2];

  always_comb begin
    sin_val[0][0]  = hav_q;
    sin_val[0][1]  = hinv_q;
    for (int l = 0; l < 2; l++) begin
      sin_root[0][l] = '0;
      sin_rem[0][l]  = '0;
    end
    for (int k = 1; k < SQRT_STEPS; k++) begin
      for (int l = 0; l < 2; l++) begin
        sin_val[k][l]  = sq_val_q[k-1][l];
        sin_root[k][l] = sq_root_q[k-1][l];
        sin_rem[k][l]  = sq_rem_q[k-1][l];
      end
    end
    for (int k = 0; k < SQRT_STEPS; k++) begin
      for (int l = 0; l < 2; l++) begin
        sq_word[k][l]  = {1'b0, sin_val[k][l], 30'd0};
        sq_next[k][l]  = {sin_rem[k][l][32:0], sq_word[k][l][61-2*k -: 2]};
        sq_trial[k][l] = {1'b0, sin_root[k][l], 2'b01};
        if (sq_next[k][l] >= sq_trial[k][l]) begin
          sq_rem_d[k][l]  = sq_next[k][l] - sq_trial[k][l];
          sq_root_d[k][l] = {sin_root[k][l][30:0], 1'b1};
        end else begin
          sq_rem_d[k][l]  = sq_next[k][l];
          sq_root_d[k][l] = {sin_root[k][l][30:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_val_q  <= sin_val;
      sq_root_q <= sq_root_d;
      sq_rem_q  <= sq_rem_d;
    end
  end

  // ---------------------------------------------------------------------
  // atan2(sqrt(a), sqrt(1-a)) by cordic vectoring, angle in turns
  // ---------------------------------------------------------------------
  logic signed [33:0] vin_x [CORDIC_STEPS];
  logic signed [33:0] vin_y [CORDIC_STEPS];
  logic signed [33:0] vin_z [CORDIC_STEPS];
  logic signed [33:0] vec_x_d [CORDIC_STEPS];
  logic signed [33:0] vec_y_d [CORDIC_STEPS];
  logic signed [33:0] vec_z_d [CORDIC_STEPS];
  logic signed [33:0] vec_x_q [CORDIC_STEPS];
  logic signed [33:0] vec_y_q [CORDIC_STEPS];
  logic signed [33:0] vec_z_q [CORDIC_STEPS];

  always_comb begin
    vin_y[0] = $signed({3'b000, sq_root_q[SQRT_STEPS-1][0][30:0]});
    vin_x[0] = $signed({3'b000, sq_root_q[SQRT_STEPS-1][1][30:0]});
    vin_z[0] = '0;
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      vin_x[i] = vec_x_q[i-1];
      vin_y[i] = vec_y_q[i-1];
      vin_z[i] = vec_z_q[i-1];
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (vin_y[i] > 34'sd0) begin
        vec_x_d[i] = vin_x[i] + (vin_y[i] >>> i);
        vec_y_d[i] = vin_y[i] - (vin_x[i] >>> i);
        vec_z_d[i] = vin_z[i] + 34'(ATAN_TURNS[i]);
      end else begin
        vec_x_d[i] = vin_x[i] - (vin_y[i] >>> i);
        vec_y_d[i] = vin_y[i] + (vin_x[i] >>> i);
        vec_z_d[i] = vin_z[i] - 34'(ATAN_TURNS[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vec_x_q <= vec_x_d;
      vec_y_q <= vec_y_d;
      vec_z_q <= vec_z_d;
    end
  end

  // ---------------------------------------------------------------------
  // clamp to a quarter turn, scale by 4 * pi * R in two partial products
  // ---------------------------------------------------------------------
  logic signed [33:0] ang_raw;
  logic [30:0] ang_c;
  logic [47:0] phi_q;
  logic [45:0] plo_q;
  logic [63:0] dist_sum;
  logic [22:0] dist_q;

  always_comb begin
    ang_raw = vec_z_q[CORDIC_STEPS-1];
    if (ang_raw[33]) begin
      ang_c = '0;
    end else if (ang_raw > $signed({3'b000, ONE_Q30})) begin
      ang_c = ONE_Q30;
    end else begin
      ang_c = ang_raw[30:0];
    end
    dist_sum = {phi_q, 16'd0} + 64'(plo_q) + DIST_RND;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      phi_q  <= 48'(ang_c) * 48'(DIST_KHI);
      plo_q  <= 46'(ang_c) * 46'(DIST_KLO);
      dist_q <= dist_sum[62:40];
    end
  end

  assign distance_o = dist_q;

endmodule

`default_nettype wire

// File: rtl/gcd_checker.sv
`default_nettype none
`include "assert_macros.svh"

module gcd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic signed [23:0] lat_a_i,
  input logic signed [24:0] lon_a_i,
  input logic signed [23:0] lat_b_i,
  input logic signed [24:0] lon_b_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic        [22:0] distance_o
);
  import gcd_pkg::*;

  // a waiting result stays put until its transfer
  `GCD_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(distance_o)), "stalled result changed")

  // the pipe must take input whenever the output side can move
  `GCD_ASSERT_IMP(a_ready_free, clk_i, rst_ni, (!out_valid_o || out_ready_i), in_ready_o, "input blocked with free output")

  // distance never beyond half the circumference
  `GCD_ASSERT_IMP(a_dist_max, clk_i, rst_ni, out_valid_o, (distance_o <= DIST_MAX), "distance above half circumference")

endmodule

bind great_circle_distance_top gcd_checker u_gcd_checker (.*);

`default_nettype wire

// File: tb/sv/tb_great_circle_distance_top.sv
`default_nettype none

module tb_great_circle_distance_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gcd_pkg::*;

  localparam int LAT_MAX  = 5898240;   // 90 degrees
  localparam int LON_MAX  = 11796480;  // 180 degrees
  localparam int N_RANDOM = 1130;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic signed [23:0] lat_a;
    logic signed [24:0] lon_a;
    logic signed [23:0] lat_b;
    logic signed [24:0] lon_b;
    bit                 drain_first;  // wait for the pipe to empty before sending
  } point_pair_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [23:0] lat_a_i = '0;
  logic signed [24:0] lon_a_i = '0;
  logic signed [23:0] lat_b_i = '0;
  logic signed [24:0] lon_b_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic        [22:0] distance_o;

  point_pair_t       pending_pairs[$];
  logic [22:0]       expected_km[$];
  int                n_errors = 0;
  int                n_sent = 0;
  int                n_checked = 0;
  int                n_cycles = 0;

  great_circle_distance_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .lat_a_i     (lat_a_i),
    .lon_a_i     (lon_a_i),
    .lat_b_i     (lat_b_i),
    .lon_b_i     (lon_b_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .distance_o  (distance_o)
  );

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // distance predictor
  // ---------------------------------------------------------------------------

  // degrees scaled by num/45 into a 32 bit turn, round half away from zero
  function automatic logic [31:0] deg_to_turn(input longint num);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + 22) / 45;
    if (num < 0) q = -q;
    return q[31:0];
  endfunction

  // rotation mode cordic, angle in turns, outputs in q30
  function automatic void turn_sin_cos(input logic [31:0] t, output longint s,
                                       output longint c);
    bit                 flip;
    logic [31:0]        tr;
    logic signed [31:0] ts;
    longint             x, y, z, xs, ys;
    flip = (t[31:30] == 2'd1) || (t[31:30] == 2'd2);
    tr = flip ? t - 32'h8000_0000 : t;
    ts = tr;
    z = ts;
    x = INV_GAIN;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(ATAN_TURNS[i]);
      end else begin
        x += ys; y -= xs; z += longint'(ATAN_TURNS[i]);
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  // floor square root, digit by digit
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned rem, res, rb;
    rem = v;
    res = 0;
    rb = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (rem >= res + rb) begin
        rem -= res + rb;
        res = (res >> 1) + rb;
      end else begin
        res >>= 1;
      end
      rb >>= 2;
    end
    return res;
  endfunction

  // vectoring mode cordic, returns the angle in turn units
  function automatic longint vector_angle(input longint y0, input longint x0);
    longint x, y, z, xs, ys;
    x = x0;
    y = y0;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += longint'(ATAN_TURNS[i]);
      end else begin
        x -= ys; y += xs; z -= longint'(ATAN_TURNS[i]);
      end
    end
    return z;
  endfunction

  function automatic logic [22:0] haversine_km(input point_pair_t p);
    longint          la, oa, lb, ob;
    longint          s1, s2, c1, c2, unused, cc, hv, ang;
    longint unsigned ry, rx, km_fix;
    la = p.lat_a;
    oa = p.lon_a;
    lb = p.lat_b;
    ob = p.lon_b;
    turn_sin_cos(deg_to_turn((lb - la) * 4096), s1, unused);
    turn_sin_cos(deg_to_turn((ob - oa) * 4096), s2, unused);
    turn_sin_cos(deg_to_turn(la * 8192), unused, c1);
    turn_sin_cos(deg_to_turn(lb * 8192), unused, c2);
    cc = (c1 * c2) >>> 30;
    hv = ((s1 * s1) >>> 30) + ((cc * ((s2 * s2) >>> 30)) >>> 30);
    // rounding and wild latitudes can push the haversine term out of [0,1]
    if (hv < 0) hv = 0;
    if (hv > longint'(ONE_Q30)) hv = ONE_Q30;
    ry = floor_root(longint'(hv) << 30);
    rx = floor_root((longint'(ONE_Q30) - hv) << 30);
    ang = vector_angle(ry, rx);
    if (ang < 0) ang = 0;
    if (ang > longint'(ONE_Q30)) ang = ONE_Q30;
    km_fix = (longint'(ang) * 64'd5246834913 + (64'd1 << 39)) >> 40;
    return km_fix[22:0];
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_pair(input int la, input int oa, input int lb, input int ob,
                          input bit drain = 1'b0);
    point_pair_t p;
    p.lat_a = la[23:0];
    p.lon_a = oa[24:0];
    p.lat_b = lb[23:0];
    p.lon_b = ob[24:0];
    p.drain_first = drain;
    pending_pairs.push_back(p);
  endtask

  function automatic int rand_lat();
    return int'($urandom_range(2 * LAT_MAX)) - LAT_MAX;
  endfunction

  function automatic int rand_lon();
    return int'($urandom_range(2 * LON_MAX)) - LON_MAX;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int rand_gap(input bit quiet);
    int r;
    r = $urandom_range(99);
    if (quiet) return 0;
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what);
    n_errors++;
    $display("[%0t] error: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------
  // driver: one nonblocking update per input per edge
  // ---------------------------------------------------------------------------
  int  send_gap = 0;
  bit  send_quiet = 1'b0;

  always @(posedge clk_i) begin
    point_pair_t nxt;
    bit          hold_valid;
    if (rst_ni) begin
      hold_valid = in_valid_i;
      // transfer on this edge: predict and retire the item
      if (in_valid_i && in_ready_o) begin
        expected_km.push_back(haversine_km(pending_pairs[0]));
        void'(pending_pairs.pop_front());
        n_sent++;
        hold_valid = 1'b0;
        send_gap = rand_gap(send_quiet);
        if ($urandom_range(99) < 2) send_quiet = !send_quiet;
      end
      if (!hold_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_pairs.size() > 0) begin
          nxt = pending_pairs[0];
          // hold off until the pipe has drained for a drain-marked item
          if (!nxt.drain_first || expected_km.size() == 0) begin
            pending_pairs[0].drain_first = 1'b0;
            lat_a_i <= nxt.lat_a;
            lon_a_i <= nxt.lon_a;
            lat_b_i <= nxt.lat_b;
            lon_b_i <= nxt.lon_b;
            hold_valid = 1'b1;
          end
        end
      end
      in_valid_i <= hold_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor and receiver stalls
  // ---------------------------------------------------------------------------
  int  stall_gap = 0;
  bit  recv_quiet = 1'b0;

  always @(posedge clk_i) begin
    logic [22:0] want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_km.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected", distance_o));
        end else begin
          want = expected_km.pop_front();
          n_checked++;
          if (distance_o !== want) begin
            report_mismatch($sformatf("distance %0d, expected %0d", distance_o, want));
          end
        end
      end
      if (stall_gap > 0) begin
        stall_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        stall_gap = rand_gap(recv_quiet);
        if ($urandom_range(99) < 2) recv_quiet = !recv_quiet;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", n_cycles,
               expected_km.size());
      $display("great_circle_distance_top: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    int la, lb;
    // directed: same point, poles, antipodes, date line, field extremes
    add_pair(0, 0, 0, 0);
    add_pair(LAT_MAX, 0, -LAT_MAX, 0);
    add_pair(0, 0, 0, LON_MAX);
    add_pair(0, -LON_MAX, 0, LON_MAX);
    add_pair(0, LON_MAX - 65536, 0, -LON_MAX + 65536);
    add_pair(LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
    add_pair(-LAT_MAX, 1234567, -LAT_MAX, -7654321);
    add_pair(3342336, 1703936, 3342336, 1703937);
    add_pair(1, 0, 0, 0);
    add_pair(0, 0, 0, 5898240);
    add_pair(3300000, -300000, -2200000, 9000000);
    add_pair(-2200000, 9000000, 3300000, -300000);
    // out of range patterns, latitudes past the poles
    add_pair(-8388608, -16777216, 8388607, 16777215);
    add_pair(8388607, 16777215, -8388608, -16777216);
    add_pair(-1, -1, -1, -1);
    add_pair(7000000, 0, -7000000, 100);
    add_pair(LAT_MAX + 1, LON_MAX + 1, -LAT_MAX - 1, -LON_MAX - 1, 1'b1);
    add_pair(0, 0, 0, 1);
    add_pair(LAT_MAX, 0, LAT_MAX - 1, 0);
    add_pair(0, 0, 0, 0, 1'b1);

    for (int n = 0; n < N_RANDOM; n++) begin
      case ($urandom_range(9))
        0: add_pair($urandom, $urandom, $urandom, $urandom);  // any bit pattern
        1: begin
          // near latitudes, longitudes drawn independently
          la = rand_lat();
          lb = la + int'($urandom_range(2000)) - 1000;
          add_pair(la, rand_lon(), lb, rand_lon() >>> 8);
        end
        2: begin
          // near antipodes
          la = rand_lat();
          add_pair(la, 0, -la + int'($urandom_range(200)) - 100,
                   LON_MAX - int'($urandom_range(300)));
        end
        default: add_pair(rand_lat(), rand_lon(), rand_lat(), rand_lon(),
                          (n % 400) == 399);
      endcase
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_pairs.size() == 0 && !in_valid_i);
    wait (expected_km.size() == 0);
    repeat (LATENCY + 20) @(posedge clk_i);

    $display("sent %0d point pairs, checked %0d distances, both sides stalled at random",
             n_sent, n_checked);
    $display("covered poles, antipodes, date line, wrapped out of range coordinates");
    if (n_errors == 0 && expected_km.size() == 0) begin
      $display("great_circle_distance_top: match");
    end else begin
      $display("great_circle_distance_top: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
